// ----- hdl/assert_macros.svh -----
// assertion macros shared by the checker files
// no dependencies; every macro expects signals named clk and rst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- hdl/tbaf_pkg.sv -----
// shared types and constants of the trimmed block average filter
// no dependencies
package tbaf_pkg;

    localparam int BLOCK_SIZE_DEF = 10;
    localparam int CHANNELS_DEF   = 3;

    localparam int CHAN_W      = 2;
    localparam int SAMPLE_W    = 24;
    localparam int SUM_W       = 31;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [CHAN_W-1:0] BATTERY_CH = 2'd2;

    // one classified word between front and back
    typedef struct packed {
        logic                       ok;
        logic [CHAN_W-1:0]          channel;
        logic signed [SAMPLE_W-1:0] sample;
        logic                       done;
        logic signed [SUM_W-1:0]    trimmed;
    } tbaf_word_t;

    typedef struct packed {
        logic full;
        logic empty;
    } tbaf_qstat_t;

endpackage

// ----- hdl/tbaf_front.sv -----
// front part: accepts words, keeps per-channel running sum, max and min
// depends on tbaf_pkg
module tbaf_front #(
    parameter int BLOCK_SIZE = tbaf_pkg::BLOCK_SIZE_DEF,
    parameter int CHANNELS   = tbaf_pkg::CHANNELS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 item_valid,
    output logic                                 item_stall,
    input  logic [tbaf_pkg::CHAN_W-1:0]          channel,
    input  logic signed [tbaf_pkg::SAMPLE_W-1:0] sample,
    input  tbaf_pkg::tbaf_qstat_t                qstat,
    output logic                                 push,
    output tbaf_pkg::tbaf_word_t                 push_word
);
    import tbaf_pkg::*;

    localparam int FILL_W = $clog2(BLOCK_SIZE);
    localparam int CH_IW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    logic [FILL_W-1:0]          fill_reg [CHANNELS];
    logic signed [SUM_W-1:0]    sum_reg  [CHANNELS];
    logic signed [SAMPLE_W-1:0] max_reg  [CHANNELS];
    logic signed [SAMPLE_W-1:0] min_reg  [CHANNELS];

    logic [CH_IW-1:0]           idx;
    logic                       ok;
    logic                       first;
    logic                       done;
    logic signed [SUM_W-1:0]    s_ext;
    logic signed [SUM_W-1:0]    sum_next;
    logic signed [SAMPLE_W-1:0] max_next;
    logic signed [SAMPLE_W-1:0] min_next;
    logic signed [SUM_W-1:0]    max_ext;
    logic signed [SUM_W-1:0]    min_ext;

    assign item_stall = qstat.full;
    assign push       = item_valid && !qstat.full;

    assign idx   = channel[CH_IW-1:0];
    assign ok    = (channel < CHAN_W'(CHANNELS));
    assign first = (fill_reg[idx] == '0);
    assign done  = (fill_reg[idx] == FILL_W'(BLOCK_SIZE - 1));
    assign s_ext = {{(SUM_W-SAMPLE_W){sample[SAMPLE_W-1]}}, sample};

    always_comb
    begin
        if (first)
        begin
            sum_next = s_ext;
            max_next = sample;
            min_next = sample;
        end
        else
        begin
            sum_next = sum_reg[idx] + s_ext;
            max_next = (sample > max_reg[idx]) ? sample : max_reg[idx];
            min_next = (sample < min_reg[idx]) ? sample : min_reg[idx];
        end
    end

    assign max_ext = {{(SUM_W-SAMPLE_W){max_next[SAMPLE_W-1]}}, max_next};
    assign min_ext = {{(SUM_W-SAMPLE_W){min_next[SAMPLE_W-1]}}, min_next};

    always_comb
    begin
        push_word.ok      = ok;
        push_word.channel = channel;
        push_word.sample  = sample;
        push_word.done    = ok && done;
        push_word.trimmed = sum_next - max_ext - min_ext;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                fill_reg[i] <= '0;
                sum_reg[i]  <= '0;
            end
        end
        else if (push && ok)
        begin
            if (done)
            begin
                fill_reg[idx] <= '0;
                sum_reg[idx]  <= '0;
            end
            else
            begin
                fill_reg[idx] <= fill_reg[idx] + 1'b1;
                sum_reg[idx]  <= sum_next;
            end
        end
    end

    // extremes are loaded by the first word of a block, no reset needed
    always_ff @(posedge clk)
    begin
        if (push && ok)
        begin
            max_reg[idx] <= max_next;
            min_reg[idx] <= min_next;
        end
    end

endmodule

// ----- hdl/tbaf_queue.sv -----
// short queue of classified words between front and back
// depends on tbaf_pkg
module tbaf_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  tbaf_pkg::tbaf_word_t  push_word,
    input  logic                  pop,
    output tbaf_pkg::tbaf_word_t  pop_word,
    output tbaf_pkg::tbaf_qstat_t qstat
);
    import tbaf_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    tbaf_word_t        slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_reg;
    logic [PTR_W-1:0]  rd_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              do_push;
    logic              do_pop;

    assign qstat.full  = (cnt_reg == CNT_W'(QUEUE_DEPTH));
    assign qstat.empty = (cnt_reg == '0);
    assign do_push     = push && !qstat.full;
    assign do_pop      = pop && !qstat.empty;
    assign pop_word    = slot_reg[rd_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_reg <= (wr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_reg <= (rd_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_reg + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   cnt_reg <= cnt_reg + 1'b1;
                2'b01:   cnt_reg <= cnt_reg - 1'b1;
                default: cnt_reg <= cnt_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_reg] <= push_word;
        end
    end

endmodule

// ----- hdl/tbaf_back.sv -----
// back part: constant divide of the trimmed sum, held values, output register
// depends on tbaf_pkg
module tbaf_back #(
    parameter int BLOCK_SIZE = tbaf_pkg::BLOCK_SIZE_DEF,
    parameter int CHANNELS   = tbaf_pkg::CHANNELS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  tbaf_pkg::tbaf_qstat_t                qstat,
    input  tbaf_pkg::tbaf_word_t                 pop_word,
    output logic                                 pop,
    output logic                                 result_valid,
    input  logic                                 result_stall,
    output logic signed [tbaf_pkg::SAMPLE_W-1:0] filtered,
    output logic                                 block_done
);
    import tbaf_pkg::*;

    localparam int DIV     = BLOCK_SIZE - 2;
    localparam int MAG_W   = SUM_W - 1;
    localparam int RECIP_W = MAG_W + 1;
    localparam int PROD_W  = MAG_W + RECIP_W;
    localparam int CH_IW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    // floor(2^MAG_W / DIV): the estimate is low by at most one
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << MAG_W) / DIV);

    tbaf_word_t                 a_word_reg;
    logic                       a_valid_reg;
    logic                       a_neg_reg;
    logic [MAG_W-1:0]           a_mag_reg;
    logic [PROD_W-1:0]          a_prod_reg;

    logic                       out_valid_reg;
    logic signed [SAMPLE_W-1:0] filtered_reg;
    logic                       done_reg;
    logic signed [SAMPLE_W-1:0] held_reg [CHANNELS];

    logic                       a_adv;
    logic                       load_a;
    logic                       neg;
    logic [SUM_W-1:0]           t_abs;
    logic [MAG_W-1:0]           q_est;
    logic [MAG_W-1:0]           qd;
    logic [MAG_W-1:0]           rem;
    logic [MAG_W-1:0]           q;
    logic [SAMPLE_W-1:0]        q24;
    logic signed [SAMPLE_W-1:0] avg;
    logic signed [SAMPLE_W-1:0] held_new;
    logic signed [SAMPLE_W-1:0] result;
    logic [CH_IW-1:0]           idx;

    assign a_adv  = a_valid_reg && (!out_valid_reg || !result_stall);
    assign pop    = !a_valid_reg || a_adv;
    assign load_a = pop && !qstat.empty;

    assign neg   = pop_word.trimmed[SUM_W-1];
    assign t_abs = neg ? (~pop_word.trimmed + 1'b1) : pop_word.trimmed;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            a_valid_reg <= !qstat.empty;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_a)
        begin
            a_word_reg <= pop_word;
            a_neg_reg  <= neg;
            a_mag_reg  <= t_abs[MAG_W-1:0];
            a_prod_reg <= t_abs[MAG_W-1:0] * RECIP;
        end
    end

    // one correction step after the reciprocal estimate
    always_comb
    begin
        q_est = a_prod_reg[MAG_W +: MAG_W];
        qd    = MAG_W'(q_est * MAG_W'(DIV));
        rem   = a_mag_reg - qd;
        q     = (rem >= MAG_W'(DIV)) ? q_est + 1'b1 : q_est;
        q24   = q[SAMPLE_W-1:0];
        avg   = a_neg_reg ? (~q24 + 1'b1) : q24;
    end

    assign idx      = a_word_reg.channel[CH_IW-1:0];
    assign held_new = a_word_reg.done ? avg : held_reg[idx];

    always_comb
    begin
        if (!a_word_reg.ok)
        begin
            result = '0;
        end
        else if (a_word_reg.channel == BATTERY_CH && held_new == '0)
        begin
            result = a_word_reg.sample;
        end
        else
        begin
            result = held_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            for (int i = 0; i < CHANNELS; i++)
            begin
                held_reg[i] <= '0;
            end
        end
        else
        begin
            if (a_adv)
            begin
                out_valid_reg <= 1'b1;
                if (a_word_reg.done)
                begin
                    held_reg[idx] <= avg;
                end
            end
            else if (!result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_adv)
        begin
            filtered_reg <= result;
            done_reg     <= a_word_reg.done;
        end
    end

    assign result_valid = out_valid_reg;
    assign filtered     = filtered_reg;
    assign block_done   = done_reg;

endmodule

// ----- hdl/trimmed_block_average_filter.sv -----
// trimmed block average filter: one sample in, one filtered word out
// usage notes below; uses tbaf_pkg, tbaf_front, tbaf_queue and tbaf_back
//
// Input channel: item_valid / item_stall with channel and sample. Output
// channel: result_valid / result_stall with filtered and block_done. A word
// moves at a rising edge where valid is high and stall is low.
// Every input word gives exactly one output word, in order. Each channel
// collects BLOCK_SIZE samples; the word that completes a block carries
// block_done and the new trimmed average (sum less max and min, divided by
// BLOCK_SIZE - 2, truncated toward zero). Channel 3, or any channel not
// below CHANNELS, gives 0 and leaves all state alone. On the battery
// channel a held value of zero passes the raw sample instead.
// Words pass the queue, the divide stage and the output register; one word
// per cycle is sustained while result_stall is low, set by the running sum,
// max/min update up front and the two-stage reciprocal divide in the back.
// Reset clears block counts, sums and held values, so every channel
// outputs 0 (battery: the raw sample) until its first block completes.
// While result_stall is high the result holds; a two-entry queue and the
// divide stage absorb words until item_stall rises.
module trimmed_block_average_filter #(
    parameter int BLOCK_SIZE = tbaf_pkg::BLOCK_SIZE_DEF,
    parameter int CHANNELS   = tbaf_pkg::CHANNELS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 item_valid,
    output logic                                 item_stall,
    input  logic [tbaf_pkg::CHAN_W-1:0]          channel,
    input  logic signed [tbaf_pkg::SAMPLE_W-1:0] sample,
    output logic                                 result_valid,
    input  logic                                 result_stall,
    output logic signed [tbaf_pkg::SAMPLE_W-1:0] filtered,
    output logic                                 block_done
);
    import tbaf_pkg::*;

    tbaf_qstat_t qstat;
    tbaf_word_t  push_word;
    tbaf_word_t  pop_word;
    logic        push;
    logic        pop;

    tbaf_front #(
        .BLOCK_SIZE (BLOCK_SIZE),
        .CHANNELS   (CHANNELS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .channel    (channel),
        .sample     (sample),
        .qstat      (qstat),
        .push       (push),
        .push_word  (push_word)
    );

    tbaf_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_word (push_word),
        .pop       (pop),
        .pop_word  (pop_word),
        .qstat     (qstat)
    );

    tbaf_back #(
        .BLOCK_SIZE (BLOCK_SIZE),
        .CHANNELS   (CHANNELS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .qstat        (qstat),
        .pop_word     (pop_word),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .filtered     (filtered),
        .block_done   (block_done)
    );

endmodule

// ----- hdl/tbaf_checker.sv -----
// port-level checker for the trimmed block average filter, bound to the top
// depends on tbaf_pkg and assert_macros.svh
`include "assert_macros.svh"

module tbaf_port_checker (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 item_stall,
    input logic                                 result_valid,
    input logic                                 result_stall,
    input logic signed [tbaf_pkg::SAMPLE_W-1:0] filtered,
    input logic                                 block_done
);

    // a stalled result stays offered
    `ASSERT_NEXT(a_hold_valid, result_valid && result_stall, result_valid)

    // a stalled result keeps its payload
    `ASSERT_NEXT(a_hold_data, result_valid && result_stall, $stable({filtered, block_done}))

    // an output side that stays idle means the pipeline has drained
    `ASSERT_NOW(a_drain, !result_valid ##1 !result_valid ##1 !result_valid, !item_stall)

    // a word must pass the queue and the divide stage, so nothing is offered as reset ends
    `ASSERT_NOW(a_no_early, $rose(rst_n), !result_valid ##1 !result_valid)

endmodule

bind trimmed_block_average_filter tbaf_port_checker u_checker (.*);
